// File: rtl/ert_pkg.sv
// Shared types, constants and register codes for the echo reply RTT statistics block.
// Used by every module in the rtl folder; depends on nothing.
package ert_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_SENT      = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_FOREIGN   = 3'd2,
        ST_NOT_REPLY = 3'd3,
        ST_SHORT     = 3'd4,
        ST_AFTER     = 3'd5
    } t_status;

    // Configuration register indexes (byte address divided by four).
    localparam int          PADDR_W        = 4;
    localparam logic [1:0]  REG_OWN_ID     = 2'd0;
    localparam logic [1:0]  REG_FINAL_CNT  = 2'd1;
    localparam logic [1:0]  REG_SEQ_OFFSET = 2'd2;

    // Register reset values.
    localparam logic [15:0] OWN_ID_RST     = 16'd0;
    localparam logic [15:0] FINAL_CNT_RST  = 16'd64;
    localparam logic [15:0] SEQ_OFFSET_RST = 16'd0;

    // Length limits of the ICMP message.
    localparam logic [15:0] MIN_ICMP_LEN   = 16'd8;
    localparam logic [15:0] MIN_REPLY_LEN  = 16'd16;

    // Seconds difference is clamped to this window before scaling. Outside of it the
    // microsecond difference can no longer pull the result back across zero or 2^32.
    localparam int          DSEC_W         = 14;
    localparam logic signed [32:0] DSEC_LO = -33'sd2;
    localparam logic signed [32:0] DSEC_HI = 33'sd4298;
    localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;
    localparam int          PROD_W         = 34;
    localparam int          DUSEC_W        = 21;

    // Default depth of the queue between front and back.
    localparam int          QUEUE_DEPTH    = 2;

    // Item held in the front register after classification.
    typedef struct packed {
        t_status             status;
        logic [15:0]         icmp_bytes;
        logic [16:0]         shown_seq;
        logic [7:0]          ttl;
        logic                seq_last;
        logic [DSEC_W-1:0]   dsec;
        logic [DUSEC_W-1:0]  dusec;
    } t_front;

    // Item held in the queue, with the scaled seconds difference.
    typedef struct packed {
        t_status             status;
        logic [15:0]         icmp_bytes;
        logic [16:0]         shown_seq;
        logic [7:0]          ttl;
        logic                seq_last;
        logic [PROD_W-1:0]   sec_us;
        logic [DUSEC_W-1:0]  dusec;
    } t_item;

    // One result transfer.
    typedef struct packed {
        t_status      status;
        logic [31:0]  rtt_us;
        logic [16:0]  shown_seq;
        logic [7:0]   ttl_out;
        logic [15:0]  icmp_bytes;
        logic         final_reply;
        logic [31:0]  min_rtt;
        logic [31:0]  max_rtt;
        logic [47:0]  total_rtt;
        logic [31:0]  replies;
        logic [31:0]  sent;
    } t_result;

endpackage

// File: rtl/ert_front.sv
// Front part: accepts input transfers, classifies packets and prepares the RTT terms.
// Depends on ert_pkg; feeds ert_fifo.
module ert_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [3:0]           i_header_words,
    input  logic [15:0]          i_packet_len,
    input  logic [7:0]           i_icmp_kind,
    input  logic [15:0]          i_icmp_ident,
    input  logic [15:0]          i_echo_seq,
    input  logic [7:0]           i_ip_ttl,
    input  logic [31:0]          i_send_sec,
    input  logic [19:0]          i_send_usec,
    input  logic [31:0]          i_recv_sec,
    input  logic [19:0]          i_recv_usec,
    input  logic [15:0]          i_own_id,
    input  logic [15:0]          i_final_count,
    input  logic [15:0]          i_seq_offset,
    input  logic                 i_full,
    output logic                 o_push,
    output ert_pkg::t_item       o_item
);

    logic               r_valid;
    logic               n_valid;
    ert_pkg::t_front    r_stage;
    ert_pkg::t_front    n_stage;
    logic               accept;
    logic [5:0]         hdr_bytes;
    logic [15:0]        ibytes;
    logic signed [32:0] dsec;
    logic signed [ert_pkg::PROD_W-1:0] sec_us;

    // Handshake: the stage frees up whenever its item moves into the queue.
    assign o_in_stall = r_valid & i_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_full;
    assign n_valid    = accept | (r_valid & i_full);

    // Classification of the incoming item.
    always_comb begin
        hdr_bytes = {i_header_words, 2'b00};
        ibytes    = (i_packet_len > {10'd0, hdr_bytes}) ?
                    (i_packet_len - {10'd0, hdr_bytes}) : 16'd0;
        dsec      = $signed({1'b0, i_recv_sec}) - $signed({1'b0, i_send_sec});

        n_stage            = '0;
        n_stage.shown_seq  = {1'b0, i_echo_seq} + {1'b0, i_seq_offset};
        n_stage.ttl        = i_ip_ttl;
        n_stage.seq_last   = (i_final_count != 16'd0) && (i_echo_seq == i_final_count - 16'd1);
        n_stage.dusec      = ert_pkg::DUSEC_W'($signed({1'b0, i_recv_usec})
                                               - $signed({1'b0, i_send_usec}));
        if (dsec < ert_pkg::DSEC_LO) begin
            n_stage.dsec = ert_pkg::DSEC_W'(ert_pkg::DSEC_LO);
        end else if (dsec > ert_pkg::DSEC_HI) begin
            n_stage.dsec = ert_pkg::DSEC_W'(ert_pkg::DSEC_HI);
        end else begin
            n_stage.dsec = ert_pkg::DSEC_W'(dsec);
        end

        if (!i_func) begin
            n_stage.status     = ert_pkg::ST_SENT;
            n_stage.icmp_bytes = 16'd0;
        end else begin
            n_stage.icmp_bytes = ibytes;
            if (ibytes < ert_pkg::MIN_ICMP_LEN) begin
                n_stage.status = ert_pkg::ST_SHORT;
            end else if (i_icmp_kind != 8'd0) begin
                n_stage.status = ert_pkg::ST_NOT_REPLY;
            end else if (i_icmp_ident != i_own_id) begin
                n_stage.status = ert_pkg::ST_FOREIGN;
            end else if (ibytes < ert_pkg::MIN_REPLY_LEN) begin
                n_stage.status = ert_pkg::ST_SHORT;
            end else begin
                n_stage.status = ert_pkg::ST_ACCEPTED;
            end
        end
    end

    // Scale the clamped seconds difference on the way into the queue.
    always_comb begin
        sec_us            = $signed(r_stage.dsec) * ert_pkg::USEC_PER_SEC;
        o_item.status     = r_stage.status;
        o_item.icmp_bytes = r_stage.icmp_bytes;
        o_item.shown_seq  = r_stage.shown_seq;
        o_item.ttl        = r_stage.ttl;
        o_item.seq_last   = r_stage.seq_last;
        o_item.sec_us     = sec_us;
        o_item.dusec      = r_stage.dusec;
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

endmodule

// File: rtl/ert_fifo.sv
// Short register queue that decouples the front from the back.
// Depends on ert_pkg for the entry type.
module ert_fifo #(
    parameter int DEPTH = ert_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ert_pkg::t_item  i_item,
    input  logic            i_pop,
    output ert_pkg::t_item  o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ert_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointer and fill count update, with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/ert_back.sv
// Back part: finishes the RTT, updates the statistics and holds the result register.
// Depends on ert_pkg; takes items from ert_fifo.
module ert_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ert_pkg::t_item   i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ert_pkg::t_result o_result
);

    logic             r_out_valid;
    ert_pkg::t_result r_out;
    ert_pkg::t_result n_out;
    logic [31:0]      r_min;
    logic [31:0]      r_max;
    logic [47:0]      r_total;
    logic [31:0]      r_replies;
    logic [31:0]      r_sent;
    logic             r_finished;
    logic [31:0]      n_min;
    logic [31:0]      n_max;
    logic [47:0]      n_total;
    logic [31:0]      n_replies;
    logic [31:0]      n_sent;
    logic             n_finished;
    logic signed [ert_pkg::PROD_W-1:0] rtt_sum;
    logic [31:0]      rtt;
    logic [48:0]      total_sum;

    // Take the queue head whenever the result register is free or being emptied.
    assign o_pop       = ~i_empty & (~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Round-trip time, clamped at zero and saturated at 32 bits.
    always_comb begin
        rtt_sum = $signed(i_head.sec_us)
                + ert_pkg::PROD_W'($signed(i_head.dusec));
        if (rtt_sum[ert_pkg::PROD_W-1]) begin
            rtt = 32'd0;
        end else if (rtt_sum[32]) begin
            rtt = '1;
        end else begin
            rtt = rtt_sum[31:0];
        end
        total_sum = {1'b0, r_total} + 49'(rtt);
    end

    // Statistics update and result assembly.
    always_comb begin
        n_min      = r_min;
        n_max      = r_max;
        n_total    = r_total;
        n_replies  = r_replies;
        n_sent     = r_sent;
        n_finished = r_finished;

        n_out            = '0;
        n_out.status     = i_head.status;
        n_out.icmp_bytes = i_head.icmp_bytes;

        if (r_finished) begin
            n_out.status     = ert_pkg::ST_AFTER;
            n_out.icmp_bytes = 16'd0;
        end else begin
            case (i_head.status)
                ert_pkg::ST_SENT: begin
                    if (r_sent != '1) begin
                        n_sent = r_sent + 32'd1;
                    end
                end
                ert_pkg::ST_ACCEPTED: begin
                    if (rtt > r_max) begin
                        n_max = rtt;
                    end
                    if (rtt < r_min) begin
                        n_min = rtt;
                    end
                    n_total = total_sum[48] ? '1 : total_sum[47:0];
                    if (r_replies != '1) begin
                        n_replies = r_replies + 32'd1;
                    end
                    n_out.rtt_us      = rtt;
                    n_out.shown_seq   = i_head.shown_seq;
                    n_out.ttl_out     = i_head.ttl;
                    n_out.final_reply = i_head.seq_last;
                    n_finished        = i_head.seq_last;
                end
                default: begin
                end
            endcase
        end

        n_out.min_rtt   = n_min;
        n_out.max_rtt   = n_max;
        n_out.total_rtt = n_total;
        n_out.replies   = n_replies;
        n_out.sent      = n_sent;
    end

    // Statistics state and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_min       <= '1;
            r_max       <= '0;
            r_total     <= '0;
            r_replies   <= '0;
            r_sent      <= '0;
            r_finished  <= 1'b0;
        end else begin
            r_out_valid <= o_pop | (r_out_valid & i_out_stall);
            if (o_pop) begin
                r_min      <= n_min;
                r_max      <= n_max;
                r_total    <= n_total;
                r_replies  <= n_replies;
                r_sent     <= n_sent;
                r_finished <= n_finished;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    // Once the run has finished, every item taken is reported as after finish.
    a_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && o_pop) |=> (r_out.status == ert_pkg::ST_AFTER))
        else $error("item after finish not reported as such");

    // With at least one reply counted, the minimum never exceeds the maximum.
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_replies != 32'd0) |-> (r_min <= r_max))
        else $error("minimum RTT above maximum RTT");

    // A final reply is an accepted reply and leaves the run finished.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.final_reply) |->
        ((r_out.status == ert_pkg::ST_ACCEPTED) && r_finished))
        else $error("final reply flag without accepted status or finish");

endmodule

// File: rtl/echo_reply_rtt_statistics.sv
// Top level of the echo reply RTT statistics block: APB registers and the three parts.
// Depends on ert_pkg, ert_front, ert_fifo and ert_back.
//
// The block takes one transfer per clock cycle while its input is not stalled, either a
// send event or the header fields of a received IPv4 packet, and returns exactly one
// result transfer for each. A transfer is classified in the front register, is scaled
// into the queue (QUEUE_DEPTH entries), and is finished in the back stage, which updates
// the minimum, maximum, total and counts and loads the result register. A result becomes
// valid once its transfer has passed the front register and the queue and has been loaded
// into the result register; one result leaves per cycle as long as the output is not
// stalled, the one statistics update per cycle in the back stage setting that rate.
// Stalls on the output fill the result register, the queue and the front register before
// the input stalls. Registers own_id, final_count and seq_offset sit at byte addresses
// 0, 4 and 8 and should only be written while no transfer is in flight.
module echo_reply_rtt_statistics #(
    parameter int QUEUE_DEPTH = ert_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ert_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [3:0]                  i_header_words,
    input  logic [15:0]                 i_packet_len,
    input  logic [7:0]                  i_icmp_kind,
    input  logic [15:0]                 i_icmp_ident,
    input  logic [15:0]                 i_echo_seq,
    input  logic [7:0]                  i_ip_ttl,
    input  logic [31:0]                 i_send_sec,
    input  logic [19:0]                 i_send_usec,
    input  logic [31:0]                 i_recv_sec,
    input  logic [19:0]                 i_recv_usec,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [31:0]                 o_rtt_us,
    output logic [16:0]                 o_shown_seq,
    output logic [7:0]                  o_ttl_out,
    output logic [15:0]                 o_icmp_bytes,
    output logic                        o_final_reply,
    output logic [31:0]                 o_min_rtt_out,
    output logic [31:0]                 o_max_rtt_out,
    output logic [47:0]                 o_total_rtt_out,
    output logic [31:0]                 o_replies_out,
    output logic [31:0]                 o_sent_out
);

    logic [15:0]      r_own_id;
    logic [15:0]      r_final_count;
    logic [15:0]      r_seq_offset;
    logic             cfg_write;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    ert_pkg::t_item   push_item;
    ert_pkg::t_item   head_item;
    ert_pkg::t_result result;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id      <= ert_pkg::OWN_ID_RST;
            r_final_count <= ert_pkg::FINAL_CNT_RST;
            r_seq_offset  <= ert_pkg::SEQ_OFFSET_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                ert_pkg::REG_OWN_ID:     r_own_id      <= pwdata[15:0];
                ert_pkg::REG_FINAL_CNT:  r_final_count <= pwdata[15:0];
                ert_pkg::REG_SEQ_OFFSET: r_seq_offset  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            ert_pkg::REG_OWN_ID:     prdata = {16'd0, r_own_id};
            ert_pkg::REG_FINAL_CNT:  prdata = {16'd0, r_final_count};
            ert_pkg::REG_SEQ_OFFSET: prdata = {16'd0, r_seq_offset};
            default:                 prdata = 32'd0;
        endcase
    end

    // Front: accept and classify.
    ert_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_header_words (i_header_words),
        .i_packet_len   (i_packet_len),
        .i_icmp_kind    (i_icmp_kind),
        .i_icmp_ident   (i_icmp_ident),
        .i_echo_seq     (i_echo_seq),
        .i_ip_ttl       (i_ip_ttl),
        .i_send_sec     (i_send_sec),
        .i_send_usec    (i_send_usec),
        .i_recv_sec     (i_recv_sec),
        .i_recv_usec    (i_recv_usec),
        .i_own_id       (r_own_id),
        .i_final_count  (r_final_count),
        .i_seq_offset   (r_seq_offset),
        .i_full         (full),
        .o_push         (push),
        .o_item         (push_item)
    );

    // Queue between front and back.
    ert_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back: statistics and result register.
    ert_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    // Result fields.
    assign o_status        = result.status;
    assign o_rtt_us        = result.rtt_us;
    assign o_shown_seq     = result.shown_seq;
    assign o_ttl_out       = result.ttl_out;
    assign o_icmp_bytes    = result.icmp_bytes;
    assign o_final_reply   = result.final_reply;
    assign o_min_rtt_out   = result.min_rtt;
    assign o_max_rtt_out   = result.max_rtt;
    assign o_total_rtt_out = result.total_rtt;
    assign o_replies_out   = result.replies;
    assign o_sent_out      = result.sent;

endmodule

// File: tb/echo_reply_rtt_statistics_tb.sv
// Self-checking testbench for echo_reply_rtt_statistics: directed and random packets.
// Depends on ert_pkg and the echo_reply_rtt_statistics RTL; drives both channels and APB.
`timescale 1ns / 100ps

module echo_reply_rtt_statistics_tb;

    // One input transfer as the sender sees it.
    typedef struct packed {
        logic        func;
        logic [3:0]  header_words;
        logic [15:0] packet_len;
        logic [7:0]  icmp_kind;
        logic [15:0] icmp_ident;
        logic [15:0] echo_seq;
        logic [7:0]  ip_ttl;
        logic [31:0] send_sec;
        logic [19:0] send_usec;
        logic [31:0] recv_sec;
        logic [19:0] recv_usec;
    } t_pkt_item;

    localparam longint RTT_CAP    = 64'sd4294967295;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     HOLD_AT    = 300;
    localparam int     HOLD_LEN   = 150;

    // Clock, reset and block ports.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [ert_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_func         = 1'b0;
    logic [3:0]  i_header_words = '0;
    logic [15:0] i_packet_len   = '0;
    logic [7:0]  i_icmp_kind    = '0;
    logic [15:0] i_icmp_ident   = '0;
    logic [15:0] i_echo_seq     = '0;
    logic [7:0]  i_ip_ttl       = '0;
    logic [31:0] i_send_sec     = '0;
    logic [19:0] i_send_usec    = '0;
    logic [31:0] i_recv_sec     = '0;
    logic [19:0] i_recv_usec    = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_rtt_us;
    logic [16:0] o_shown_seq;
    logic [7:0]  o_ttl_out;
    logic [15:0] o_icmp_bytes;
    logic        o_final_reply;
    logic [31:0] o_min_rtt_out;
    logic [31:0] o_max_rtt_out;
    logic [47:0] o_total_rtt_out;
    logic [31:0] o_replies_out;
    logic [31:0] o_sent_out;

    // Register copies and statistics state of the predictor.
    logic [15:0] cfg_own_id      = ert_pkg::OWN_ID_RST;
    logic [15:0] cfg_final_count = ert_pkg::FINAL_CNT_RST;
    logic [15:0] cfg_seq_offset  = ert_pkg::SEQ_OFFSET_RST;
    logic [31:0] st_min          = '1;
    logic [31:0] st_max          = '0;
    logic [47:0] st_total        = '0;
    logic [31:0] st_replies      = '0;
    logic [31:0] st_sent         = '0;
    logic        st_finished     = 1'b0;

    // Packets waiting to be driven and statistics results waiting to arrive.
    t_pkt_item        pending_pkts[$];
    ert_pkg::t_result expected_stats[$];
    t_pkt_item        cur_pkt;
    ert_pkg::t_result want_res;

    int src_gap      = 0;
    int sink_hold    = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    bit src_idle     = 1'b1;
    bit sink_idle    = 1'b1;
    bit failed       = 1'b0;

    echo_reply_rtt_statistics u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_header_words  (i_header_words),
        .i_packet_len    (i_packet_len),
        .i_icmp_kind     (i_icmp_kind),
        .i_icmp_ident    (i_icmp_ident),
        .i_echo_seq      (i_echo_seq),
        .i_ip_ttl        (i_ip_ttl),
        .i_send_sec      (i_send_sec),
        .i_send_usec     (i_send_usec),
        .i_recv_sec      (i_recv_sec),
        .i_recv_usec     (i_recv_usec),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_rtt_us        (o_rtt_us),
        .o_shown_seq     (o_shown_seq),
        .o_ttl_out       (o_ttl_out),
        .o_icmp_bytes    (o_icmp_bytes),
        .o_final_reply   (o_final_reply),
        .o_min_rtt_out   (o_min_rtt_out),
        .o_max_rtt_out   (o_max_rtt_out),
        .o_total_rtt_out (o_total_rtt_out),
        .o_replies_out   (o_replies_out),
        .o_sent_out      (o_sent_out)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Classifies one packet, updates the statistics and returns the result it must produce.
    function automatic ert_pkg::t_result update_stats(input t_pkt_item it);
        ert_pkg::t_result r;
        logic [15:0] hlen;
        logic [15:0] ibytes;
        longint      ss, su, rs, ru, d;
        logic [31:0] rtt;
        logic [48:0] tsum;
        r = '0;
        if (st_finished) begin
            r.status = ert_pkg::ST_AFTER;
        end else if (!it.func) begin
            r.status = ert_pkg::ST_SENT;
            if (st_sent != '1) st_sent++;
        end else begin
            hlen   = {10'd0, it.header_words, 2'b00};
            ibytes = (it.packet_len > hlen) ? it.packet_len - hlen : 16'd0;
            r.icmp_bytes = ibytes;
            if (ibytes < ert_pkg::MIN_ICMP_LEN) begin
                r.status = ert_pkg::ST_SHORT;
            end else if (it.icmp_kind != 8'd0) begin
                r.status = ert_pkg::ST_NOT_REPLY;
            end else if (it.icmp_ident != cfg_own_id) begin
                r.status = ert_pkg::ST_FOREIGN;
            end else if (ibytes < ert_pkg::MIN_REPLY_LEN) begin
                r.status = ert_pkg::ST_SHORT;
            end else begin
                // Exact microsecond difference, clamped at zero and saturated at 32 bits.
                ss = it.send_sec;
                su = it.send_usec;
                rs = it.recv_sec;
                ru = it.recv_usec;
                d  = (rs - ss) * 64'sd1000000 + (ru - su);
                if (d < 0) rtt = '0;
                else if (d > RTT_CAP) rtt = '1;
                else rtt = d[31:0];
                if (rtt > st_max) st_max = rtt;
                if (rtt < st_min) st_min = rtt;
                tsum     = {1'b0, st_total} + {17'd0, rtt};
                st_total = tsum[48] ? '1 : tsum[47:0];
                if (st_replies != '1) st_replies++;
                r.status    = ert_pkg::ST_ACCEPTED;
                r.rtt_us    = rtt;
                r.shown_seq = {1'b0, it.echo_seq} + {1'b0, cfg_seq_offset};
                r.ttl_out   = it.ip_ttl;
                if (cfg_final_count != 16'd0 && it.echo_seq == cfg_final_count - 16'd1) begin
                    r.final_reply = 1'b1;
                    st_finished   = 1'b1;
                end
            end
        end
        r.min_rtt   = st_min;
        r.max_rtt   = st_max;
        r.total_rtt = st_total;
        r.replies   = st_replies;
        r.sent      = st_sent;
        return r;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_len();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 3);
        else if (r < 95) len = $urandom_range(4, 10);
        else len = $urandom_range(20, 60);
        return len;
    endfunction

    // Random packet: mostly well-formed replies, some send events, broken replies and noise.
    function automatic t_pkt_item random_pkt();
        t_pkt_item   p;
        int          pick;
        logic [15:0] hl;
        p.func         = 1'b1;
        p.header_words = 4'($urandom);
        p.packet_len   = 16'($urandom);
        p.icmp_kind    = 8'($urandom);
        p.icmp_ident   = 16'($urandom);
        p.echo_seq     = 16'($urandom);
        p.ip_ttl       = 8'($urandom);
        p.send_sec     = $urandom;
        p.send_usec    = 20'($urandom_range(0, 999999));
        p.recv_sec     = $urandom;
        p.recv_usec    = 20'($urandom_range(0, 999999));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            p.func = 1'b0;
        end else if (pick < 90) begin
            // Echo reply with our identifier and a plausible pair of timestamps.
            if ($urandom_range(0, 3) != 0) p.header_words = 4'd5;
            hl = {10'd0, p.header_words, 2'b00};
            case ($urandom_range(0, 5))
                0: p.packet_len = hl + 16'd16;
                1: p.packet_len = 16'($urandom_range(hl + 16, 65535));
                default: p.packet_len = hl + 16'($urandom_range(16, 120));
            endcase
            p.icmp_kind  = 8'd0;
            p.icmp_ident = cfg_own_id;
            case ($urandom_range(0, 9))
                6: p.recv_sec = p.send_sec - $urandom_range(0, 3);
                7: p.recv_sec = p.send_sec + $urandom_range(4294, 4295);
                8: begin
                    p.recv_sec  = p.send_sec + $urandom_range(0, 1);
                    p.send_usec = 20'($urandom);
                    p.recv_usec = 20'($urandom);
                end
                9: p.recv_usec = 20'($urandom);
                default: p.recv_sec = p.send_sec + $urandom_range(0, 2);
            endcase
            // Spoil one property of some of them.
            if (pick >= 75) begin
                case ($urandom_range(0, 2))
                    0: p.packet_len = 16'($urandom_range(0, hl + 15));
                    1: p.icmp_kind = 8'($urandom_range(1, 255));
                    default: p.icmp_ident = cfg_own_id ^ (16'd1 << $urandom_range(0, 15));
                endcase
            end
        end
        // Keep the run from finishing before the last phase.
        if (cfg_final_count != 16'd0 && p.echo_seq == cfg_final_count - 16'd1)
            p.echo_seq[0] = ~p.echo_seq[0];
        return p;
    endfunction

    task automatic add_pkt(input logic f, input logic [3:0] hw, input logic [15:0] plen,
                           input logic [7:0] kind, input logic [15:0] ident, seq,
                           input logic [7:0] ttl, input logic [31:0] ss,
                           input logic [19:0] su, input logic [31:0] rs,
                           input logic [19:0] ru);
        pending_pkts.push_back('{f, hw, plen, kind, ident, seq, ttl, ss, su, rs, ru});
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ert_pkg::REG_OWN_ID:     cfg_own_id      = val;
            ert_pkg::REG_FINAL_CNT:  cfg_final_count = val;
            ert_pkg::REG_SEQ_OFFSET: cfg_seq_offset  = val;
            default: ;
        endcase
    endtask

    // Waits until every packet is driven and every result has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pkts.size() != 0 || i_in_valid || expected_stats.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [47:0] want, got);
        if (want !== got) begin
            failed = 1'b1;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Input driver: predicts each accepted transfer and loads the next packet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) expected_stats.push_back(update_stats(cur_pkt));
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pkts.size() > 0) begin
                    cur_pkt = pending_pkts.pop_front();
                    i_func         <= cur_pkt.func;
                    i_header_words <= cur_pkt.header_words;
                    i_packet_len   <= cur_pkt.packet_len;
                    i_icmp_kind    <= cur_pkt.icmp_kind;
                    i_icmp_ident   <= cur_pkt.icmp_ident;
                    i_echo_seq     <= cur_pkt.echo_seq;
                    i_ip_ttl       <= cur_pkt.ip_ttl;
                    i_send_sec     <= cur_pkt.send_sec;
                    i_send_usec    <= cur_pkt.send_usec;
                    i_recv_sec     <= cur_pkt.recv_sec;
                    i_recv_usec    <= cur_pkt.recv_usec;
                    i_in_valid     <= 1'b1;
                    src_gap = (src_idle && $urandom_range(0, 2) == 0) ? pick_len() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result transfer and decides the stall for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_stats.size() == 0) begin
                    failed = 1'b1;
                    $error("result transfer with no pending expectation");
                end else begin
                    want_res = expected_stats.pop_front();
                    check_field("status", want_res.status, o_status);
                    check_field("rtt_us", want_res.rtt_us, o_rtt_us);
                    check_field("shown_seq", want_res.shown_seq, o_shown_seq);
                    check_field("ttl_out", want_res.ttl_out, o_ttl_out);
                    check_field("icmp_bytes", want_res.icmp_bytes, o_icmp_bytes);
                    check_field("final_reply", want_res.final_reply, o_final_reply);
                    check_field("min_rtt_out", want_res.min_rtt, o_min_rtt_out);
                    check_field("max_rtt_out", want_res.max_rtt, o_max_rtt_out);
                    check_field("total_rtt_out", want_res.total_rtt, o_total_rtt_out);
                    check_field("replies_out", want_res.replies, o_replies_out);
                    check_field("sent_out", want_res.sent, o_sent_out);
                end
                results_seen++;
                // One long hold-off so the block fills up and stalls its input.
                if (results_seen == HOLD_AT) sink_hold = HOLD_LEN;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_out_stall <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 2) == 0) begin
                sink_hold = pick_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed packets under the reset configuration.
        add_pkt(0, 4'h0, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, 0, 0, 0);
        add_pkt(0, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
        add_pkt(1, 4'h0, 16'd16, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, 0, 0, 0);
        add_pkt(1, 4'hF, 16'hFFFF, 8'h00, 16'h0000, 16'hFFFF, 8'hFF, 1000, 250000, 1001, 750000);
        // Length limits and the order of the checks.
        add_pkt(1, 4'd5, 16'd27, 8'h00, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'd5, 16'd28, 8'h03, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'd5, 16'd28, 8'h00, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'd5, 16'd35, 8'h00, 16'h1234, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'd5, 16'd35, 8'h00, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'hF, 16'd20, 8'h00, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        add_pkt(1, 4'd5, 16'd36, 8'hFF, 16'h0000, 16'd1, 8'd64, 0, 0, 0, 5);
        // Negative round trips clamp to zero.
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd5, 8'd64, 500, 0, 499, 999999);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd6, 8'd64, 500, 600000, 500, 599999);
        // Exactly at and just past the 32-bit limit, then far past it.
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd7, 8'd64, 0, 0, 4294, 967295);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd8, 8'd64, 0, 0, 4294, 967296);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd9, 8'd64, 10, 0, 5010, 0);
        // Microsecond fields above 999999.
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd10, 8'd64, 7, 0, 7, 20'hFFFFF);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd11, 8'd64, 7, 20'hFFFFF, 9, 0);
        // Extreme seconds in both directions.
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd12, 8'd64, 32'hFFFFFFFF, 0, 0, 0);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd13, 8'd64,
                0, 0, 32'hFFFFFFFF, 20'hFFFFF);
        wait_idle();

        // Extreme registers; a final count of zero never finishes.
        reg_write(ert_pkg::REG_OWN_ID, 16'hFFFF);
        reg_write(ert_pkg::REG_FINAL_CNT, 16'h0000);
        reg_write(ert_pkg::REG_SEQ_OFFSET, 16'hFFFF);
        @(negedge i_clk);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'hFFFF, 16'hFFFF, 8'd1, 3, 0, 3, 42);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'h0000, 16'd2, 8'd1, 3, 0, 3, 42);
        add_pkt(1, 4'd5, 16'd100, 8'h00, 16'hFFFF, 16'h0000, 8'd1, 3, 0, 4, 42);

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            src_idle  = (p != 1);
            sink_idle = (p != 1);
            reg_write(ert_pkg::REG_OWN_ID, (p % 3 == 0) ? 16'h0000 :
                                           (p % 3 == 1) ? 16'hFFFF : 16'($urandom));
            reg_write(ert_pkg::REG_FINAL_CNT, (p % 4 == 0) ? 16'd0 : (p % 4 == 1) ? 16'd1 :
                                              (p % 4 == 2) ? 16'hFFFF :
                                              16'($urandom_range(2, 65534)));
            reg_write(ert_pkg::REG_SEQ_OFFSET, (p % 2 == 1) ? 16'($urandom) :
                                               (p == 0) ? 16'h0000 : 16'hFFFF);
            @(negedge i_clk);
            repeat (120) pending_pkts.push_back(random_pkt());
        end

        // Last phase: finish the run, then everything after it is ignored.
        wait_idle();
        reg_write(ert_pkg::REG_OWN_ID, 16'($urandom));
        reg_write(ert_pkg::REG_FINAL_CNT, 16'hFFFF);
        @(negedge i_clk);
        repeat (30) pending_pkts.push_back(random_pkt());
        add_pkt(1, 4'd5, 16'd64, 8'h00, cfg_own_id, 16'hFFFE, 8'd128, 20, 0, 20, 1234);
        add_pkt(0, 4'd0, 16'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, 0, 0, 0);
        add_pkt(1, 4'd5, 16'd64, 8'h00, cfg_own_id, 16'd3, 8'd128, 20, 0, 20, 99);
        repeat (8) pending_pkts.push_back(random_pkt());

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (!failed && expected_stats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
